[hdl/sactc_pkg.sv]
// Shared types, constants and helper functions for the set-associative cache
// tag controller. Used by the top level, the tag RAM user and the checker.
`default_nettype none

package sactc_pkg;

  // Fixed address geometry; the port widths follow from these.
  localparam int unsigned ADDR_WIDTH  = 32;
  localparam int unsigned OFFSET_BITS = 2;
  localparam int unsigned BLOCK_BITS  = 2;

  // Defaults for the storage parameters of the top level.
  localparam int unsigned WAYS_DEF     = 4;
  localparam int unsigned SET_BITS_DEF = 4;

  // Register file geometry: three 32-bit registers at byte addresses 0, 4, 8.
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  // Galois LFSR used for random victim choice.
  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  typedef enum logic [1:0] {
    REG_REPL   = 2'd0,
    REG_WPOL   = 2'd1,
    REG_WALLOC = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    REPL_LRU    = 2'd0,
    REPL_FIFO   = 2'd1,
    REPL_RANDOM = 2'd2
  } repl_e;

  typedef enum logic {
    WP_BACK    = 1'b0,
    WP_THROUGH = 1'b1
  } wpol_e;

  typedef enum logic {
    MODE_READ  = 1'b0,
    MODE_WRITE = 1'b1
  } mode_e;

  typedef struct packed {
    logic [31:0] address;
    logic        mode;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [1:0]  way_used;
    logic        allocated;
    logic [3:0]  set_index;
    logic [1:0]  block_index;
    logic        filled_invalid;
    logic        memory_write;
    logic [23:0] evicted_tag;
  } rsp_t;

  function automatic logic [15:0] lfsr_step(input logic [15:0] cur);
    logic [15:0] nxt;
    nxt = cur >> 1;
    if (cur[0]) begin
      nxt = nxt ^ LFSR_TAPS;
    end
    return nxt;
  endfunction

endpackage

`default_nettype wire

[hdl/set_assoc_cache_tag_controller_top.sv]
// A request accepted at a clock edge moves into the input register, and from there
// into the result register that drives the result strobe. Throughput: one request
// every cycle; busy is never raised and the result receiver cannot stall. The tag
// RAM read on acceptance and the read-modify-write of one set per cycle allow this.
// Reset clears valid bits, the LFSR and the registers; the tag RAM is not cleared.
// Depends on sactc_pkg and sactc_ram.
`default_nettype none

module set_assoc_cache_tag_controller_top #(
  parameter int unsigned WAYS     = sactc_pkg::WAYS_DEF,
  parameter int unsigned SET_BITS = sactc_pkg::SET_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Request channel
  input  wire logic                           start,
  output logic                                busy,
  input  wire sactc_pkg::req_t                req_i,
  // Result channel
  output logic                                rsp_valid_o,
  output sactc_pkg::rsp_t                     rsp_o,
  // Register port
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [sactc_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [sactc_pkg::PDATA_W-1:0]  pwdata,
  output logic      [sactc_pkg::PDATA_W-1:0]  prdata,
  output logic                                pready
);

  // Geometry derived from the parameters.
  localparam int unsigned SETS      = 1 << SET_BITS;
  localparam int unsigned SIW       = SET_BITS > 0 ? SET_BITS : 1;
  localparam int unsigned WIW       = WAYS > 1 ? $clog2(WAYS) : 1;
  localparam int unsigned AW        = WIW;
  localparam int unsigned TAG_SHIFT = sactc_pkg::OFFSET_BITS + sactc_pkg::BLOCK_BITS + SET_BITS;
  localparam int unsigned TAG_W     = sactc_pkg::ADDR_WIDTH - TAG_SHIFT;
  // Each way in a RAM row holds its tag, its dirty bit and its age.
  localparam int unsigned ENTRY_W   = TAG_W + 1 + AW;
  localparam int unsigned ROW_W     = WAYS * ENTRY_W;
  localparam logic [AW-1:0] AGE_MAX = AW'(WAYS - 1);

  // ---------------------------------------------------------------------------
  // Register port. Writes land on the access phase; pready is tied high, so a
  // write never waits. Reads return the current register values.
  // ---------------------------------------------------------------------------
  logic [1:0] repl_q;
  logic       wpol_q;
  logic       walloc_q;
  logic       cfg_we;
  logic [1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repl_q   <= sactc_pkg::REPL_LRU;
      wpol_q   <= sactc_pkg::WP_BACK;
      walloc_q <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_idx)
        sactc_pkg::REG_REPL:   repl_q   <= pwdata[1:0];
        sactc_pkg::REG_WPOL:   wpol_q   <= pwdata[0];
        sactc_pkg::REG_WALLOC: walloc_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      sactc_pkg::REG_REPL:   prdata = {{(sactc_pkg::PDATA_W-2){1'b0}}, repl_q};
      sactc_pkg::REG_WPOL:   prdata = {{(sactc_pkg::PDATA_W-1){1'b0}}, wpol_q};
      sactc_pkg::REG_WALLOC: prdata = {{(sactc_pkg::PDATA_W-1){1'b0}}, walloc_q};
      default:               prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Request decode and the input register. The low two address bits sit inside
  // the byte offset, which the field slices already skip.
  // ---------------------------------------------------------------------------
  logic             accept;
  logic [SIW-1:0]   in_set;
  logic [TAG_W-1:0] in_tag;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign in_tag = req_i.address[sactc_pkg::ADDR_WIDTH-1:TAG_SHIFT];

  if (SET_BITS > 0) begin : g_set
    assign in_set = req_i.address[sactc_pkg::OFFSET_BITS + sactc_pkg::BLOCK_BITS +: SIW];
  end else begin : g_noset
    assign in_set = '0;
  end

  logic                            s_valid_q;
  logic [TAG_W-1:0]                s_tag_q;
  logic [SIW-1:0]                  s_set_q;
  logic [sactc_pkg::BLOCK_BITS-1:0] s_blk_q;
  logic                            s_write_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else begin
      s_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_tag_q   <= in_tag;
      s_set_q   <= in_set;
      s_blk_q   <= req_i.address[sactc_pkg::OFFSET_BITS +: sactc_pkg::BLOCK_BITS];
      s_write_q <= (req_i.mode == sactc_pkg::MODE_WRITE);
    end
  end

  // ---------------------------------------------------------------------------
  // Tag RAM: one row per set. The read is launched on acceptance, so the row is
  // ready when the request sits in the input register. A write to the same set
  // on that same edge is not seen by the read; the forwarding register below
  // supplies the freshly written row instead.
  // ---------------------------------------------------------------------------
  logic             ram_we;
  logic [ROW_W-1:0] ram_wdata;
  logic [ROW_W-1:0] ram_rdata;

  sactc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s_set_q),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (in_set),
    .rdata_o (ram_rdata)
  );

  logic             fwd_valid_q;
  logic [SIW-1:0]   fwd_set_q;
  logic [ROW_W-1:0] fwd_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else begin
      fwd_valid_q <= ram_we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      fwd_set_q <= s_set_q;
      fwd_row_q <= ram_wdata;
    end
  end

  // Valid bits live in flip-flops so that reset clears them at once.
  logic [WAYS-1:0] valid_q [SETS];
  logic [15:0]     lfsr_q;

  // ---------------------------------------------------------------------------
  // LFSR modulo WAYS: the byte-wise remainders come from two constant tables,
  // their sum stays below twice WAYS and is corrected with one subtract.
  // ---------------------------------------------------------------------------
  logic [15:0]    lfsr_nxt;
  logic [WIW-1:0] mod_lo [256];
  logic [WIW-1:0] mod_hi [256];
  logic [WIW:0]   mod_sum;
  logic [WIW-1:0] rand_way;

  for (genvar b = 0; b < 256; b++) begin : g_mod
    localparam int unsigned LoRem = b % WAYS;
    localparam int unsigned HiRem = (b * 256) % WAYS;
    assign mod_lo[b] = WIW'(LoRem);
    assign mod_hi[b] = WIW'(HiRem);
  end

  assign lfsr_nxt = sactc_pkg::lfsr_step(lfsr_q);
  assign mod_sum  = {1'b0, mod_lo[lfsr_nxt[7:0]]} + {1'b0, mod_hi[lfsr_nxt[15:8]]};

  always_comb begin
    if (mod_sum >= (WIW+1)'(WAYS)) begin
      rand_way = WIW'(mod_sum - (WIW+1)'(WAYS));
    end else begin
      rand_way = mod_sum[WIW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Lookup, victim choice and state update for the request in the input
  // register.
  // ---------------------------------------------------------------------------
  logic [ROW_W-1:0] row;
  logic [TAG_W-1:0] way_tag   [WAYS];
  logic             way_dirty [WAYS];
  logic [AW-1:0]    way_age   [WAYS];
  logic [WAYS-1:0]  set_valid;

  assign row       = (fwd_valid_q && fwd_set_q == s_set_q) ? fwd_row_q : ram_rdata;
  assign set_valid = valid_q[s_set_q];

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      way_tag[w]   = row[w*ENTRY_W + AW + 1 +: TAG_W];
      way_dirty[w] = row[w*ENTRY_W + AW];
      way_age[w]   = row[w*ENTRY_W +: AW];
    end
  end

  logic           hit;
  logic [WIW-1:0] hit_way;
  logic           any_invalid;
  logic [WIW-1:0] inv_way;
  logic [WIW-1:0] old_way;
  logic [AW-1:0]  old_age;
  logic           use_random;
  logic [WIW-1:0] victim;

  always_comb begin
    hit         = 1'b0;
    hit_way     = '0;
    any_invalid = 1'b0;
    inv_way     = '0;
    // Walk downwards so the lowest matching index wins.
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (set_valid[w] && way_tag[w] == s_tag_q) begin
        hit     = 1'b1;
        hit_way = WIW'(w);
      end
      if (!set_valid[w]) begin
        any_invalid = 1'b1;
        inv_way     = WIW'(w);
      end
    end
  end

  // Oldest way, lowest index on ties.
  always_comb begin
    old_way = '0;
    old_age = way_age[0];
    for (int w = 1; w < WAYS; w++) begin
      if (way_age[w] > old_age) begin
        old_way = WIW'(w);
        old_age = way_age[w];
      end
    end
  end

  assign use_random = (WAYS > 1) && !any_invalid &&
                      (repl_q != sactc_pkg::REPL_LRU) && (repl_q != sactc_pkg::REPL_FIFO);

  always_comb begin
    if (WAYS == 1) begin
      victim = '0;
    end else if (any_invalid) begin
      victim = inv_way;
    end else if (use_random) begin
      victim = rand_way;
    end else begin
      victim = old_way;
    end
  end

  logic           do_access;
  logic           alloc;
  logic [WIW-1:0] way_sel;
  logic           sel_valid;
  logic           filled_inv;
  logic           mem_wr;
  logic [TAG_W-1:0] ev_tag;
  logic           touch;
  logic           lfsr_adv;

  assign do_access  = s_valid_q && (hit || !s_write_q || walloc_q);
  assign alloc      = do_access && !hit;
  assign way_sel    = hit ? hit_way : (alloc ? victim : '0);
  assign sel_valid  = set_valid[way_sel];
  assign filled_inv = alloc && !sel_valid;
  assign ev_tag     = (alloc && sel_valid) ? way_tag[way_sel] : '0;
  assign mem_wr     = (alloc && sel_valid && way_dirty[way_sel]) ||
                      (s_valid_q && !do_access) ||
                      (s_write_q && wpol_q == sactc_pkg::WP_THROUGH);
  // LRU touches on hit and fill, FIFO on fill only.
  assign touch      = do_access && ((repl_q == sactc_pkg::REPL_LRU) ||
                                    (repl_q == sactc_pkg::REPL_FIFO && alloc));
  assign lfsr_adv   = alloc && use_random;
  assign ram_we     = do_access;

  // New row: untouched ways are written back as read.
  always_comb begin
    logic [AW-1:0] age_n;
    logic          dirty_n;
    logic [TAG_W-1:0] tag_n;
    ram_wdata = row;
    for (int w = 0; w < WAYS; w++) begin
      age_n   = way_age[w];
      dirty_n = way_dirty[w];
      tag_n   = way_tag[w];
      if (WIW'(w) == way_sel) begin
        if (alloc) begin
          tag_n   = s_tag_q;
          dirty_n = 1'b0;
          age_n   = '0;
        end
        if (s_write_q && wpol_q == sactc_pkg::WP_BACK) begin
          dirty_n = 1'b1;
        end
        if (touch) begin
          age_n = '0;
        end
      end else if (touch && set_valid[w] && way_age[w] != AGE_MAX &&
                   (alloc || way_age[w] < way_age[way_sel])) begin
        // A fill counts as the oldest way, so every other valid way not yet at AGE_MAX ages.
        age_n = way_age[w] + AW'(1);
      end
      ram_wdata[w*ENTRY_W +: ENTRY_W] = {tag_n, dirty_n, age_n};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SETS; s++) begin
        valid_q[s] <= '0;
      end
      lfsr_q <= sactc_pkg::LFSR_SEED;
    end else begin
      if (alloc) begin
        valid_q[s_set_q][way_sel] <= 1'b1;
      end
      if (lfsr_adv) begin
        lfsr_q <= lfsr_nxt;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register. Output fields are cut or zero-extended to the port widths.
  // ---------------------------------------------------------------------------
  logic [31:0]     way_ext;
  logic [31:0]     set_ext;
  logic [31:0]     tag_ext;
  logic            rsp_valid_q;
  sactc_pkg::rsp_t rsp_q;

  assign way_ext = 32'(way_sel);
  assign set_ext = 32'(s_set_q);
  assign tag_ext = 32'(ev_tag);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= s_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_q) begin
      rsp_q.hit            <= hit;
      rsp_q.way_used       <= way_ext[1:0];
      rsp_q.allocated      <= alloc;
      rsp_q.set_index      <= set_ext[3:0];
      rsp_q.block_index    <= s_blk_q;
      rsp_q.filled_invalid <= filled_inv;
      rsp_q.memory_write   <= mem_wr;
      rsp_q.evicted_tag    <= tag_ext[23:0];
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

`default_nettype wire

[hdl/sactc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module sactc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                        wdata_i,
  input  wire logic                                    re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hdl/sactc_checker.sv]
// Port-level checker for the cache tag controller and its bind statement.
// Depends on sactc_pkg and set_assoc_cache_tag_controller_top.
`default_nettype none

module sactc_checker (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            start,
  input wire logic            busy,
  input wire logic            rsp_valid_o,
  input wire sactc_pkg::rsp_t rsp_o
);

  // Every accepted request yields exactly one result, and every result has a request.
  a_latency_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 rsp_valid_o)
    else $error("request without result two cycles later");

  a_latency_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> $past(start && !busy, 2))
    else $error("result without a matching request");

  // A fill of an invalid way only follows a miss and evicts nothing.
  a_fill_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.filled_invalid) |->
      (rsp_o.allocated && !rsp_o.hit && rsp_o.evicted_tag == 24'd0))
    else $error("invalid-way fill reported inconsistently");

  // A miss that allocates nothing is a write around the cache.
  a_no_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && !rsp_o.hit && !rsp_o.allocated) |->
      (rsp_o.way_used == 2'd0 && rsp_o.memory_write))
    else $error("non-allocating miss without memory write");

endmodule

bind set_assoc_cache_tag_controller_top sactc_checker u_sactc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .rsp_valid_o (rsp_valid_o),
  .rsp_o       (rsp_o)
);

`default_nettype wire
